FILE: hw/rtl/htks_pkg.sv
// Shared types and constants of the histogram top-k selection unit.
`default_nettype none

package htks_pkg;

	localparam int MAX_VALUES_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam int VAL_W        = 7;
	localparam int RESULT_LIMIT = 64;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_NUM_VALUES = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_NUM_PICKS  = 1'd1;

	localparam logic [VAL_W-1:0] NUM_VALUES_RST = 7'd49;
	localparam logic [VAL_W-1:0] NUM_PICKS_RST  = 7'd6;

	typedef struct packed {
		logic [VAL_W-1:0] drawn_value;
		logic             last_draw;
	} draw_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] picked_value;
		logic             final_pick;
	} pick_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/htks_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module htks_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/histogram_top_k_select_unit.sv
// Top level of the histogram top-k selection unit: counting, scan sequencer, APB registers.
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------------
// draw      | in        | draw_valid / draw_stall   | drawn_value, last_draw
// pick      | out       | pick_valid / pick_stall   | picked_value, final_pick
// apb       | in / out  | psel, penable, pready     | paddr, pwdata (write), prdata (read)
//
// A draw reads the count RAM in its transfer cycle and writes it back in the next cycle.
// A draw flagged last then runs one scan per pick through the single count RAM read port,
// over span entries (span = min(num_values, MAX_VALUES)); a pick may wait under pick_stall.
// Counts and pick marks clear via flop valid bits, so reset needs no clearing pass. Draws
// stall while the block is busy.

module histogram_top_k_select_unit #(
	parameter int MAX_VALUES = htks_pkg::MAX_VALUES_DEF,
	parameter int COUNT_BITS = htks_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             draw_valid,
	output logic                                  draw_stall,
	input  wire htks_pkg::draw_item_t             draw,
	output logic                                  pick_valid,
	input  wire logic                             pick_stall,
	output htks_pkg::pick_item_t                  pick,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [htks_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [htks_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [htks_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready
);

	import htks_pkg::*;

	localparam int IDX_W  = $clog2(MAX_VALUES);
	localparam int SPAN_W = $clog2(MAX_VALUES + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_UPDATE = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_n;

	// Configuration registers
	logic [VAL_W-1:0] num_values_q;
	logic [VAL_W-1:0] num_picks_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	// Histogram bookkeeping
	logic [MAX_VALUES-1:0] vld_q;
	logic [MAX_VALUES-1:0] picked_q;

	// Draw update
	logic [IDX_W-1:0] upd_idx_q;
	logic upd_hit_q;
	logic upd_last_q;

	// Scan
	logic [SPAN_W-1:0] scan_addr_q;
	logic scan_vld_s1;
	logic [IDX_W-1:0] scan_idx_s1;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [IDX_W-1:0] best_idx_q;
	logic best_found_q;
	logic [VAL_W-1:0] pick_cnt_q;

	// Output register
	pick_item_t pick_q;

	// Combinational helpers
	logic [SPAN_W-1:0] span;
	logic [VAL_W-1:0] picks;
	logic [31:0] drawn_ext;
	logic draw_hit;
	logic [IDX_W-1:0] draw_idx;
	logic draw_xfer;
	logic pick_xfer;
	logic scan_issue;
	logic scan_done;
	logic [COUNT_BITS-1:0] upd_cur;
	logic [COUNT_BITS-1:0] scan_cur;
	logic scan_better;
	logic is_final;
	logic hist_clr;

	logic ram_we;
	logic [IDX_W-1:0] ram_raddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [COUNT_BITS-1:0] ram_rdata;

	// APB: writes complete in the access phase, no wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_NUM_VALUES: prdata = APB_DATA_W'(num_values_q);
			REG_NUM_PICKS:  prdata = APB_DATA_W'(num_picks_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_values_q <= NUM_VALUES_RST;
			num_picks_q  <= NUM_PICKS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NUM_VALUES: num_values_q <= pwdata[VAL_W-1:0];
				REG_NUM_PICKS:  num_picks_q  <= pwdata[VAL_W-1:0];
				default:        ;
			endcase
		end
	end

	// Clamp the value range to the histogram depth and the pick count to the result limit
	always_comb begin
		if (32'(num_values_q) > 32'(MAX_VALUES)) begin
			span = SPAN_W'(MAX_VALUES);
		end else begin
			span = SPAN_W'(num_values_q);
		end
		if (32'(num_picks_q) > 32'(RESULT_LIMIT)) begin
			picks = VAL_W'(RESULT_LIMIT);
		end else begin
			picks = num_picks_q;
		end
	end

	// Draw decode: values 1..span map to entries 0..span-1
	assign drawn_ext = 32'(draw.drawn_value);
	assign draw_hit  = (drawn_ext != 32'd0) && (drawn_ext <= 32'(span));
	assign draw_idx  = IDX_W'(drawn_ext - 32'd1);

	assign draw_stall = (state_q != ST_IDLE);
	assign draw_xfer  = draw_valid & ~draw_stall;

	assign pick_valid = (state_q == ST_EMIT);
	assign pick       = pick_q;
	assign pick_xfer  = pick_valid & ~pick_stall;

	// An entry whose valid bit is clear reads as a zero count
	assign upd_cur  = vld_q[upd_idx_q] ? ram_rdata : '0;
	assign scan_cur = vld_q[scan_idx_s1] ? ram_rdata : '0;

	// Strict compare keeps the lowest value on ties and skips zero counts
	assign scan_better = scan_vld_s1 && !picked_q[scan_idx_s1] && (scan_cur > best_cnt_q);
	assign scan_issue  = (state_q == ST_SCAN) && (scan_addr_q < span);
	assign scan_done   = (state_q == ST_SCAN) && !scan_issue && !scan_vld_s1;
	assign is_final    = ((pick_cnt_q + 7'd1) == picks);

	// Drop the histogram after a last draw with no picks, or after the final pick
	assign hist_clr = ((state_q == ST_UPDATE) && upd_last_q && (picks == '0))
		|| (pick_xfer && is_final);

	// Count RAM: write back a saturating increment in the update cycle
	assign ram_we    = (state_q == ST_UPDATE) && upd_hit_q && (upd_cur != '1);
	assign ram_wdata = upd_cur + COUNT_BITS'(1);
	assign ram_raddr = (state_q == ST_SCAN) ? scan_addr_q[IDX_W-1:0] : draw_idx;

	htks_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_VALUES)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(upd_idx_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (draw_xfer) begin
					state_n = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (upd_last_q && (picks != '0)) begin
					state_n = ST_SCAN;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (pick_xfer) begin
					state_n = is_final ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_q        <= '0;
			picked_q     <= '0;
			upd_hit_q    <= 1'b0;
			upd_last_q   <= 1'b0;
			scan_addr_q  <= '0;
			scan_vld_s1  <= 1'b0;
			best_cnt_q   <= '0;
			best_found_q <= 1'b0;
			pick_cnt_q   <= '0;
		end else begin
			state_q <= state_n;

			// Hold the draw while its count is read
			if (draw_xfer) begin
				upd_hit_q  <= draw_hit;
				upd_last_q <= draw.last_draw;
			end

			if (hist_clr) begin
				vld_q <= '0;
			end else if (ram_we) begin
				vld_q[upd_idx_q] <= 1'b1;
			end

			// Start the first pick of a run
			if ((state_q == ST_UPDATE) && upd_last_q) begin
				scan_addr_q  <= '0;
				best_cnt_q   <= '0;
				best_found_q <= 1'b0;
				pick_cnt_q   <= '0;
				// Zero picks: drop the pick marks at once
				if (picks == '0) begin
					picked_q <= '0;
				end
			end

			// Advance the scan one entry per cycle
			scan_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_addr_q <= scan_addr_q + SPAN_W'(1);
			end
			if (scan_better) begin
				best_cnt_q   <= scan_cur;
				best_found_q <= 1'b1;
			end

			// Remove the winner from later picks
			if (scan_done && best_found_q) begin
				picked_q[best_idx_q] <= 1'b1;
			end

			if (pick_xfer) begin
				if (is_final) begin
					picked_q <= '0;
				end else begin
					pick_cnt_q   <= pick_cnt_q + 7'd1;
					scan_addr_q  <= '0;
					best_cnt_q   <= '0;
					best_found_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (draw_xfer) begin
			upd_idx_q <= draw_idx;
		end
		if (scan_issue) begin
			scan_idx_s1 <= scan_addr_q[IDX_W-1:0];
		end
		if (scan_better) begin
			best_idx_q <= scan_idx_s1;
		end
		if (scan_done) begin
			pick_q.picked_value <= best_found_q ? VAL_W'(32'(best_idx_q) + 32'd1) : '0;
			pick_q.final_pick   <= is_final;
		end
	end

endmodule

`default_nettype wire
